// ----- rtl/core/sequence_count_to_calendar_assert.svh -----
// Assertion macros for the count-to-calendar block.
// Included by the top level; needs nothing else.
`ifndef SEQUENCE_COUNT_TO_CALENDAR_ASSERT_SVH
`define SEQUENCE_COUNT_TO_CALENDAR_ASSERT_SVH

// same-cycle implication
`define SCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/scc_pkg.sv -----
// Types and constants of the count-to-calendar block.
// Used by scc_civil and sequence_count_to_calendar; depends on nothing.
package scc_pkg;

  typedef enum logic [1:0] {
    UNIT_DAY  = 2'd0,
    UNIT_HOUR = 2'd1,
    UNIT_MIN  = 2'd2
  } unit_e;

  // year is two's complement
  typedef struct packed {
    logic [23:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } civ_date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
  } hm_t;

  localparam int CIV_LAT = 8;

  localparam longint DAYS_4Y   = 365 * 4 + 1;
  localparam longint DAYS_100Y = DAYS_4Y * 25 - 1;
  localparam longint DAYS_400Y = DAYS_100Y * 4 + 1;
  localparam longint MAR2000   = 72743;
  localparam longint CYC_BIAS  = 14700;
  localparam longint TWO31     = longint'(1) << 31;

  // biased day index: day 0 of 1801-01-01 moved so that all counts stay non-negative
  localparam longint W_BASE = CYC_BIAS * DAYS_400Y - MAR2000;
  localparam longint HOUR_K = (TWO31 + 23) / 24;
  localparam longint MIN_K  = (TWO31 + 1439) / 1440;

  localparam logic [32:0] X_OFF_HOUR = 33'(HOUR_K * 24 - TWO31);
  localparam logic [32:0] X_OFF_MIN  = 33'(MIN_K * 1440 - TWO31);
  localparam logic [32:0] X_OFF_DAY  = 33'(W_BASE - 1 - TWO31);
  localparam logic [32:0] W_OFF_HOUR = 33'(W_BASE - HOUR_K);
  localparam logic [32:0] W_OFF_MIN  = 33'(W_BASE - MIN_K);

  localparam logic [30:0] RCP3   = 31'(((longint'(1) << 32) + 2) / 3);
  localparam logic [30:0] RCP45  = 31'(((longint'(1) << 34) + 44) / 45);
  localparam logic [9:0]  RCP15  = 10'(((longint'(1) << 13) + 14) / 15);
  localparam logic [33:0] RCP_CYC = 34'(((longint'(1) << 51) + DAYS_400Y - 1) / DAYS_400Y);
  localparam logic [16:0] RCP_4Y  = 17'(((longint'(1) << 27) + DAYS_4Y - 1) / DAYS_4Y);

  localparam logic [23:0] YEAR_BASE = 24'(2000 - CYC_BIAS * 400);

  localparam logic [17:0] D400  = 18'(DAYS_400Y);
  localparam logic [17:0] D100  = 18'(DAYS_100Y);
  localparam logic [15:0] D4    = 16'(DAYS_4Y);
  localparam logic [10:0] D1    = 11'd365;

  // first day of each March-based month within the year
  function automatic logic [8:0] month_start(input logic [3:0] j);
    logic [8:0] s;
    unique case (j)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/scc_civil.sv -----
// Eight-stage pipeline from a biased day index to year, month and day.
// Depends on scc_pkg.
module scc_civil import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] w_i,
  output civ_date_t   date_o
);

  logic [49:0] pl1_q, ph1_q;
  logic [32:0] w1_q, w2_q;
  logic [66:0] sum2;
  logic [15:0] q2_q;
  logic [17:0] r3_q;
  logic [23:0] y3_q, y4_q, y5_q, y6_q, y7_q;
  logic [1:0]  c4;
  logic [15:0] r4_q, r5_q;
  logic [31:0] p5_q;
  logic [4:0]  g6;
  logic [10:0] r6_q;
  logic [1:0]  n7;
  logic [8:0]  r7_q;
  logic [3:0]  j8;
  logic [8:0]  d8;
  civ_date_t   date_d, date_q;

  assign sum2 = {ph1_q, 17'b0} + 67'(pl1_q);
  assign c4 = 2'(r3_q >= D100) + 2'(r3_q >= 18'(2 * DAYS_100Y)) +
              2'(r3_q >= 18'(3 * DAYS_100Y));
  assign g6 = p5_q[31:27];
  assign n7 = 2'(r6_q >= D1) + 2'(r6_q >= 11'd730) + 2'(r6_q >= 11'd1095);

  always_comb begin
    j8 = '0;
    for (int i = 1; i < 12; i++) begin
      j8 = j8 + 4'(r7_q >= month_start(4'(i)));
    end
    d8 = r7_q - month_start(j8) + 9'd1;
    date_d.day = d8[4:0];
    if (j8 >= 4'd10) begin
      date_d.month = j8 - 4'd9;
      date_d.year  = y7_q + 24'd1;
    end else begin
      date_d.month = j8 + 4'd3;
      date_d.year  = y7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl1_q  <= 50'(w_i) * 50'(RCP_CYC[16:0]);
      ph1_q  <= 50'(w_i) * 50'(RCP_CYC[33:17]);
      w1_q   <= w_i;
      q2_q   <= sum2[66:51];
      w2_q   <= w1_q;
      r3_q   <= w2_q[17:0] - 18'(q2_q) * D400;
      y3_q   <= 24'(q2_q) * 24'd400 + YEAR_BASE;
      r4_q   <= 16'(r3_q - 18'(c4) * D100);
      y4_q   <= y3_q + 24'(c4) * 24'd100;
      p5_q   <= 32'(r4_q) * 32'(RCP_4Y);
      r5_q   <= r4_q;
      y5_q   <= y4_q;
      r6_q   <= 11'(r5_q - 16'(g6) * D4);
      y6_q   <= y5_q + 24'({g6, 2'b00});
      r7_q   <= 9'(r6_q - 11'(n7) * D1);
      y7_q   <= y6_q + 24'(n7);
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

// ----- rtl/core/sequence_count_to_calendar.sv -----
// Converts a signed day, hour or minute count since 1801-01-01 into a
// Gregorian year, month, day, hour and minute. Fully pipelined: one item
// per cycle while the output is not stalled. A stalled output holds the
// whole pipeline, so the input is ready unless an output item is stalled.
// Depends on scc_pkg, scc_civil and sequence_count_to_calendar_assert.svh.
`include "sequence_count_to_calendar_assert.svh"

module sequence_count_to_calendar import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // count_unit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // seq_count[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata     // year[23:0], month[27:24], day_of_month[32:28],
                                       // hour[37:33], minute[43:38], zero pad
);

  localparam int TOP_LAT  = 3;
  localparam int PIPE_LAT = TOP_LAT + CIV_LAT;
  localparam int HM_DEPTH = CIV_LAT - 1;

  unit_e unit_q, unit_d;
  logic  en;
  logic [PIPE_LAT-1:0] vld_q;

  logic [31:0] u1;
  logic [32:0] x1_d, x1_q, x2_q;
  unit_e       mode1_q, mode2_q, mode3_q, mode4_q;
  logic [29:0] v2;
  logic [30:0] m2;
  logic [60:0] prod2_q;
  logic [28:0] q3h;
  logic [26:0] q3m;
  logic [5:0]  rh6, rm6;
  logic [32:0] w3_d, w3_q;
  logic [10:0] tod3_d, tod3_q, tod4_q;
  logic [18:0] p4_q;
  logic [4:0]  h5;
  logic [5:0]  mn5;
  hm_t         hm5_d;
  hm_t         hm_q [HM_DEPTH];
  civ_date_t   date;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i == UNIT_HOUR) begin
      unit_d = UNIT_HOUR;
    end else if (cfg_data_i == UNIT_MIN) begin
      unit_d = UNIT_MIN;
    end else begin
      unit_d = UNIT_DAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_DAY;
    end else if (cfg_valid_i) begin
      unit_q <= unit_d;
    end
  end

  assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // bias the count so that floor division works on unsigned values
  assign u1 = {~s_axis_tdata[31], s_axis_tdata[30:0]};

  always_comb begin
    unique case (unit_q)
      UNIT_HOUR: x1_d = {1'b0, u1} + X_OFF_HOUR;
      UNIT_MIN:  x1_d = {1'b0, u1} + X_OFF_MIN;
      default:   x1_d = {1'b0, u1} + X_OFF_DAY;
    endcase
  end

  assign v2 = (mode1_q == UNIT_HOUR) ? x1_q[32:3] : {2'b00, x1_q[32:5]};
  assign m2 = (mode1_q == UNIT_HOUR) ? RCP3 : RCP45;

  assign q3h = prod2_q[60:32];
  assign q3m = prod2_q[60:34];
  assign rh6 = x2_q[8:3] - q3h[5:0] * 6'd3;
  assign rm6 = x2_q[10:5] - q3m[5:0] * 6'd45;

  always_comb begin
    unique case (mode2_q)
      UNIT_HOUR: begin
        w3_d   = 33'(q3h) + W_OFF_HOUR;
        tod3_d = {6'b0, rh6[1:0], x2_q[2:0]};
      end
      UNIT_MIN: begin
        w3_d   = 33'(q3m) + W_OFF_MIN;
        tod3_d = {rm6, x2_q[4:0]};
      end
      default: begin
        w3_d   = x2_q;
        tod3_d = '0;
      end
    endcase
  end

  assign h5  = p4_q[17:13];
  assign mn5 = tod4_q[5:0] - {1'b0, h5} * 6'd60;

  always_comb begin
    unique case (mode4_q)
      UNIT_HOUR: begin
        hm5_d.hour   = tod4_q[4:0];
        hm5_d.minute = '0;
      end
      UNIT_MIN: begin
        hm5_d.hour   = h5;
        hm5_d.minute = mn5;
      end
      default: begin
        hm5_d.hour   = '0;
        hm5_d.minute = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= x1_d;
      mode1_q  <= unit_q;
      prod2_q  <= 61'(v2) * 61'(m2);
      x2_q     <= x1_q;
      mode2_q  <= mode1_q;
      w3_q     <= w3_d;
      tod3_q   <= tod3_d;
      mode3_q  <= mode2_q;
      p4_q     <= 19'(tod3_q[10:2]) * 19'(RCP15);
      tod4_q   <= tod3_q;
      mode4_q  <= mode3_q;
      hm_q[0]  <= hm5_d;
      for (int i = 1; i < HM_DEPTH; i++) begin
        hm_q[i] <= hm_q[i-1];
      end
    end
  end

  scc_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (en),
    .w_i    (w3_q),
    .date_o (date)
  );

  assign m_axis_tvalid = vld_q[PIPE_LAT-1];
  assign m_axis_tdata  = {4'b0, hm_q[HM_DEPTH-1].minute, hm_q[HM_DEPTH-1].hour,
                          date.day, date.month, date.year};

  `SCC_ASSERT_IMPL(a_month_range, clk_i, rst_ni, m_axis_tvalid,
    (date.month != 4'd0) && (date.month <= 4'd12) && (date.day != 5'd0),
    "month or day out of range")
  `SCC_ASSERT_IMPL(a_time_range, clk_i, rst_ni, m_axis_tvalid,
    (hm_q[HM_DEPTH-1].hour < 5'd24) && (hm_q[HM_DEPTH-1].minute < 6'd60),
    "hour or minute out of range")
  `SCC_ASSERT_IMPL(a_backpressure, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    !s_axis_tready, "input taken while output stalled")
  `SCC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    $stable(vld_q), "pipeline moved during stall")

endmodule

// ----- tb/calendar_checker.sv -----
`timescale 1ns / 100ps
// Watches the unit, count and date streams of sequence_count_to_calendar,
// predicts each date from the count and the current unit, and compares.
// Depends on scc_pkg for the unit codes.
module calendar_checker import scc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        cnt_valid_i,
  input  logic        cnt_ready_i,
  input  logic [31:0] cnt_data_i,
  input  logic        date_valid_i,
  input  logic        date_ready_i,
  input  logic [47:0] date_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam longint QUAD_DAYS   = 365 * 4 + 1;
  localparam longint CENT_DAYS   = QUAD_DAYS * 25 - 1;
  localparam longint ERA_DAYS    = CENT_DAYS * 4 + 1;
  localparam longint MAR2000_DAY = 72743;
  localparam longint DAY_MINUTES = 24 * 60;
  localparam int     SHOWN_FAILS = 10;

  typedef struct packed {
    logic [23:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } cal_t;

  logic [1:0] count_unit;
  cal_t       expected_dates[$];
  cal_t       got, want;

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if (a % b < 0) q = q - 1;
    return q;
  endfunction

  function automatic cal_t civil_date_of(input logic [31:0] raw, input logic [1:0] unit);
    longint cnt, day_idx, hr, mn, rem, t, cyc, r, y, c, g, n, m, d;
    cal_t   res;
    cnt = longint'(signed'(raw));
    hr  = 0;
    mn  = 0;
    if (unit == UNIT_HOUR) begin
      day_idx = floor_div(cnt, 24);
      hr      = cnt - day_idx * 24;
    end else if (unit == UNIT_MIN) begin
      day_idx = floor_div(cnt, DAY_MINUTES);
      rem     = cnt - day_idx * DAY_MINUTES;
      hr      = rem / 60;
      mn      = rem % 60;
    end else begin
      day_idx = cnt - 1;
    end
    // split into 400-year eras from 2000-03-01, then centuries, quads, years
    t   = day_idx - MAR2000_DAY;
    cyc = floor_div(t, ERA_DAYS);
    r   = t - cyc * ERA_DAYS;
    y   = 2000 + cyc * 400;
    c   = r / CENT_DAYS;
    if (c == 4) c = 3;
    r = r - c * CENT_DAYS;
    y = y + c * 100;
    g = r / QUAD_DAYS;
    r = r - g * QUAD_DAYS;
    y = y + g * 4;
    n = r / 365;
    if (n == 4) n = 3;
    r = r - n * 365;
    y = y + n;
    m = (r * 10 + 4) / 306 + 3;
    d = r - ((306 * m + 6) / 10 - 93);
    if (m > 12) begin
      m = m - 12;
      y = y + 1;
    end
    res.year   = y[23:0];
    res.month  = m[3:0];
    res.day    = d[4:0];
    res.hour   = hr[4:0];
    res.minute = mn[5:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_unit = UNIT_DAY;
      expected_dates.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (date_valid_i && date_ready_i) begin
        got.year   = date_data_i[23:0];
        got.month  = date_data_i[27:24];
        got.day    = date_data_i[32:28];
        got.hour   = date_data_i[37:33];
        got.minute = date_data_i[43:38];
        if (expected_dates.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= SHOWN_FAILS)
            $display("date item with no count pending: %h", date_data_i);
        end else begin
          want = expected_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.hour !== want.hour || got.minute !== want.minute) begin
            fail_cnt_o++;
            if (fail_cnt_o <= SHOWN_FAILS)
              $display("date mismatch: exp %0d-%0d-%0d %0d:%0d, got %0d-%0d-%0d %0d:%0d",
                       $signed(want.year), want.month, want.day, want.hour, want.minute,
                       $signed(got.year), got.month, got.day, got.hour, got.minute);
          end
        end
      end
      if (cnt_valid_i && cnt_ready_i)
        expected_dates.push_back(civil_date_of(cnt_data_i, count_unit));
      if (cfg_valid_i && cfg_ready_i)
        count_unit = cfg_data_i;
      pending_o = expected_dates.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the sequence_count_to_calendar bench: clock, reset, unit writes,
// count stimulus and output back-pressure. Uses scc_pkg, calendar_checker, the DUT.
module testbench;
  import scc_pkg::*;

  localparam logic [1:0] UNIT_SPARE = 2'd3;
  localparam int PIPE_LAT   = 11;
  localparam int LONG_HOLD  = 200;
  localparam int SEG_ITEMS  = 54;
  localparam int CYCLE_CAP  = 200000;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_data;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;

  int  date_fails, dates_pending;
  int  send_idle_pct = 27;
  int  recv_idle_pct = 71;
  int  cycle_cnt     = 0;
  bit  hold_go       = 1'b0;
  bit  hold_done     = 1'b0;
  logic [1:0] unit_seq [4] = '{UNIT_DAY, UNIT_HOUR, UNIT_MIN, UNIT_SPARE};

  sequence_count_to_calendar i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  calendar_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .cnt_valid_i  (s_axis_tvalid),
    .cnt_ready_i  (s_axis_tready),
    .cnt_data_i   (s_axis_tdata),
    .date_valid_i (m_axis_tvalid),
    .date_ready_i (m_axis_tready),
    .date_data_i  (m_axis_tdata),
    .fail_cnt_o   (date_fails),
    .pending_o    (dates_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random back-pressure, one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_count(input logic [31:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cnt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (dates_pending != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic set_unit(input logic [1:0] unit);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= unit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_count();
    logic [31:0] v;
    case ($urandom_range(4))
      0:       v = $urandom;
      1:       v = 32'h8000_0000 + $urandom_range(3000);
      2:       v = 32'h7FFF_FFFF - $urandom_range(3000);
      3:       v = $urandom_range(400000) - 200000;
      default: v = $urandom_range(300000);
    endcase
    return v;
  endfunction

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = UNIT_DAY;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_unit(UNIT_DAY);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(32'h0000_0000);
    send_count(32'h0000_0001);
    send_count(32'hFFFF_FFFF);
    send_count(32'd60);
    send_count(32'd72743);
    send_count(32'd72744);
    set_unit(UNIT_HOUR);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(32'hFFFF_FFFF);
    send_count(32'd23);
    send_count(32'd24);
    set_unit(UNIT_MIN);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(32'hFFFF_FFFF);
    send_count(32'd1439);
    send_count(32'd1440);
    set_unit(UNIT_SPARE);
    send_count(32'h0000_0001);
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 27 : 0;
      for (int k = 0; k < 4; k++) begin
        set_unit(unit_seq[(ph + k) % 4]);
        if (ph == 2 && k == 1) hold_go = 1'b1;
        repeat (SEG_ITEMS) send_count(random_count());
      end
    end

    drain();
    if (date_fails == 0 && dates_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_civil.sv
rtl/core/sequence_count_to_calendar.sv
tb/calendar_checker.sv
tb/testbench.sv
